>>> hw/rtl/srss_pkg.sv
// shared types and constants for the score ranking selection sort block
package srss_pkg;

  // fixed field widths
  localparam int unsigned SLOT_W  = 3;
  localparam int unsigned SCORE_W = 16;

  // default number of entrant slots
  localparam int unsigned ENTRANTS_DEF = 6;

  // score every slot holds after reset
  localparam logic signed [SCORE_W-1:0] RESET_SCORE = 16'sd100;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COPY,
    ST_SCAN,
    ST_SWAP
  } state_t;

endpackage

>>> hw/rtl/srss_if.sv
// valid/ready channel interfaces for score updates and ranked results
interface srss_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [srss_pkg::SLOT_W-1:0]            slot;
  logic signed [srss_pkg::SCORE_W-1:0]    new_score;

  modport source (output valid, output slot, output new_score, input ready);
  modport sink   (input valid, input slot, input new_score, output ready);
endinterface

interface srss_out_if;
  logic                                   valid;
  logic                                   ready;
  logic [srss_pkg::SLOT_W-1:0]            ranked_slot;
  logic signed [srss_pkg::SCORE_W-1:0]    ranked_score;
  logic                                   last;

  modport source (output valid, output ranked_slot, output ranked_score, output last,
                  input ready);
  modport sink   (input valid, input ranked_slot, input ranked_score, input last,
                  output ready);
endinterface

>>> hw/rtl/srss_store.sv
// persistent slot score memory with per-entry valid bits for the reset value
module srss_store #(
  parameter int unsigned ENTRANTS = srss_pkg::ENTRANTS_DEF,
  localparam int unsigned SW = $clog2(ENTRANTS)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                wr_en,
  input  logic [SW-1:0]                       wr_addr,
  input  logic signed [srss_pkg::SCORE_W-1:0] wr_score,
  input  logic                                rd_en,
  input  logic [SW-1:0]                       rd_addr,
  output logic signed [srss_pkg::SCORE_W-1:0] rd_score
);

  logic signed [srss_pkg::SCORE_W-1:0] mem [ENTRANTS];
  logic [ENTRANTS-1:0]                 valid_r;
  logic signed [srss_pkg::SCORE_W-1:0] rd_mem_r;
  logic                                rd_hit_r;

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_score;
    end
    if (rd_en) begin
      rd_mem_r <= mem[rd_addr];
    end
  end

  // written flags, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_hit_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit_r <= valid_r[rd_addr];
      end
    end
  end

  // never-written entries read as the reset score
  assign rd_score = rd_hit_r ? rd_mem_r : srss_pkg::RESET_SCORE;

endmodule

>>> hw/rtl/srss_work.sv
// working copy memory of scores and slot indexes used during the sort
module srss_work #(
  parameter int unsigned ENTRANTS = srss_pkg::ENTRANTS_DEF,
  localparam int unsigned SW = $clog2(ENTRANTS)
) (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [SW-1:0]                       wr_addr,
  input  logic signed [srss_pkg::SCORE_W-1:0] wr_score,
  input  logic [SW-1:0]                       wr_slot,
  input  logic                                rd_en,
  input  logic [SW-1:0]                       rd_addr,
  output logic signed [srss_pkg::SCORE_W-1:0] rd_score,
  output logic [SW-1:0]                       rd_slot
);

  logic signed [srss_pkg::SCORE_W-1:0] score_mem [ENTRANTS];
  logic [SW-1:0]                       slot_mem  [ENTRANTS];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      score_mem[wr_addr] <= wr_score;
      slot_mem[wr_addr]  <= wr_slot;
    end
    if (rd_en) begin
      rd_score <= score_mem[rd_addr];
      rd_slot  <= slot_mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/srss_seq.sv
// sequencer: score update, copy, max scan with shared compare, swap and emit
module srss_seq #(
  parameter int unsigned ENTRANTS = srss_pkg::ENTRANTS_DEF,
  localparam int unsigned SW   = $clog2(ENTRANTS),
  localparam int unsigned CNTW = $clog2(ENTRANTS + 1),
  localparam int unsigned CW   = (srss_pkg::SLOT_W > CNTW) ? srss_pkg::SLOT_W : CNTW
) (
  input  logic                                clk,
  input  logic                                rst_n,
  srss_in_if.sink                             in_if,
  srss_out_if.source                          out_if,
  // slot score store
  output logic                                st_wr_en,
  output logic [SW-1:0]                       st_wr_addr,
  output logic signed [srss_pkg::SCORE_W-1:0] st_wr_score,
  output logic                                st_rd_en,
  output logic [SW-1:0]                       st_rd_addr,
  input  logic signed [srss_pkg::SCORE_W-1:0] st_rd_score,
  // working memory
  output logic                                wk_wr_en,
  output logic [SW-1:0]                       wk_wr_addr,
  output logic signed [srss_pkg::SCORE_W-1:0] wk_wr_score,
  output logic [SW-1:0]                       wk_wr_slot,
  output logic                                wk_rd_en,
  output logic [SW-1:0]                       wk_rd_addr,
  input  logic signed [srss_pkg::SCORE_W-1:0] wk_rd_score,
  input  logic [SW-1:0]                       wk_rd_slot
);

  localparam logic [CNTW-1:0] CNT_END  = CNTW'(ENTRANTS);
  localparam logic [SW-1:0]   POS_LAST = SW'(ENTRANTS - 1);

  srss_pkg::state_t state_r, state_nxt;

  logic [CNTW-1:0]                     cnt_r;
  logic [SW-1:0]                       pos_r;
  logic                                srd_vld_r;
  logic [SW-1:0]                       srd_addr_r;
  logic                                wrd_vld_r;
  logic [SW-1:0]                       wrd_addr_r;
  logic [SW-1:0]                       best_idx_r;
  logic signed [srss_pkg::SCORE_W-1:0] best_score_r;
  logic [SW-1:0]                       best_slot_r;
  logic signed [srss_pkg::SCORE_W-1:0] p_score_r;
  logic [SW-1:0]                       p_slot_r;
  logic                                out_vld_r;
  logic [srss_pkg::SLOT_W-1:0]         out_slot_r;
  logic signed [srss_pkg::SCORE_W-1:0] out_score_r;
  logic                                out_last_r;

  logic [CW-1:0] slot_ext;
  logic          slot_ok;
  logic          in_xfer;
  logic          issue_more;
  logic          scan_done;
  logic          out_free;
  logic          emit;
  logic          first_ret;
  logic          take_new;

  assign slot_ext   = CW'(in_if.slot);
  assign slot_ok    = slot_ext < CW'(ENTRANTS);
  assign in_xfer    = in_if.valid && in_if.ready;
  assign issue_more = cnt_r < CNT_END;
  assign scan_done  = wrd_vld_r && (wrd_addr_r == POS_LAST);
  assign out_free   = !out_vld_r || out_if.ready;
  assign first_ret  = wrd_addr_r == pos_r;
  // shared compare: later entry wins only when strictly larger
  assign take_new   = first_ret || (best_score_r < wk_rd_score);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      srss_pkg::ST_IDLE: if (in_xfer) state_nxt = srss_pkg::ST_COPY;
      srss_pkg::ST_COPY: if (!issue_more) state_nxt = srss_pkg::ST_SCAN;
      srss_pkg::ST_SCAN: if (scan_done) state_nxt = srss_pkg::ST_SWAP;
      srss_pkg::ST_SWAP: begin
        if (out_free) begin
          state_nxt = (pos_r == POS_LAST) ? srss_pkg::ST_IDLE : srss_pkg::ST_SCAN;
        end
      end
      default: state_nxt = srss_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_if.ready = 1'b0;
    st_wr_en    = 1'b0;
    st_rd_en    = 1'b0;
    wk_wr_en    = 1'b0;
    wk_wr_addr  = srd_addr_r;
    wk_wr_score = st_rd_score;
    wk_wr_slot  = srd_addr_r;
    wk_rd_en    = 1'b0;
    emit        = 1'b0;
    case (state_r)
      srss_pkg::ST_IDLE: begin
        in_if.ready = 1'b1;
        st_wr_en    = in_if.valid && slot_ok;
      end
      srss_pkg::ST_COPY: begin
        st_rd_en = issue_more;
        wk_wr_en = srd_vld_r;
      end
      srss_pkg::ST_SCAN: begin
        wk_rd_en = issue_more;
      end
      srss_pkg::ST_SWAP: begin
        // old entry at this position moves to where the maximum was
        emit        = out_free;
        wk_wr_en    = out_free;
        wk_wr_addr  = best_idx_r;
        wk_wr_score = p_score_r;
        wk_wr_slot  = p_slot_r;
      end
      default: ;
    endcase
  end

  assign st_wr_addr  = slot_ext[SW-1:0];
  assign st_wr_score = in_if.new_score;
  assign st_rd_addr  = cnt_r[SW-1:0];
  assign wk_rd_addr  = cnt_r[SW-1:0];

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= srss_pkg::ST_IDLE;
      cnt_r     <= '0;
      pos_r     <= '0;
      srd_vld_r <= 1'b0;
      wrd_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      srd_vld_r <= st_rd_en;
      wrd_vld_r <= wk_rd_en;
      // counter and position
      if (in_xfer) begin
        cnt_r <= '0;
        pos_r <= '0;
      end else if (st_rd_en || wk_rd_en) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (state_r == srss_pkg::ST_COPY) begin
        cnt_r <= '0;
      end else if (emit) begin
        pos_r <= pos_r + 1'b1;
        cnt_r <= CNTW'(pos_r) + 1'b1;
      end
      // result register
      if (emit) begin
        out_vld_r <= 1'b1;
      end else if (out_if.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // read return tags and scan datapath
  always_ff @(posedge clk) begin
    srd_addr_r <= cnt_r[SW-1:0];
    wrd_addr_r <= cnt_r[SW-1:0];
    if (wrd_vld_r && first_ret) begin
      p_score_r <= wk_rd_score;
      p_slot_r  <= wk_rd_slot;
    end
    if (wrd_vld_r && take_new) begin
      best_idx_r   <= wrd_addr_r;
      best_score_r <= wk_rd_score;
      best_slot_r  <= wk_rd_slot;
    end
    if (emit) begin
      out_slot_r  <= srss_pkg::SLOT_W'(best_slot_r);
      out_score_r <= best_score_r;
      out_last_r  <= pos_r == POS_LAST;
    end
  end

  assign out_if.valid        = out_vld_r;
  assign out_if.ranked_slot  = out_slot_r;
  assign out_if.ranked_score = out_score_r;
  assign out_if.last         = out_last_r;

endmodule

>>> hw/rtl/score_ranking_selection_sort.sv
// top level of the score ranking block: descending selection sort over slot scores
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-------------------------------------------
//  in_if    | in  | valid / ready | slot[2:0], new_score[15:0] signed
//  out_if   | out | valid / ready | ranked_slot[2:0], ranked_score[15:0], last
//
//  an update runs a copy pass from the score store into the working memory, then a scan
//  through the working memory read port and a swap for each position
//  reset (rst_n low, synchronous) returns every slot to a score of 100 at once
//  a stalled result holds the sequencer in its swap step; a new update is taken
//  while the final result of the previous one still waits in the output register
module score_ranking_selection_sort #(
  parameter int unsigned ENTRANTS = srss_pkg::ENTRANTS_DEF,
  localparam int unsigned SW = $clog2(ENTRANTS)
) (
  input  logic        clk,
  input  logic        rst_n,
  srss_in_if.sink     in_if,
  srss_out_if.source  out_if
);

  logic                                st_wr_en;
  logic [SW-1:0]                       st_wr_addr;
  logic signed [srss_pkg::SCORE_W-1:0] st_wr_score;
  logic                                st_rd_en;
  logic [SW-1:0]                       st_rd_addr;
  logic signed [srss_pkg::SCORE_W-1:0] st_rd_score;
  logic                                wk_wr_en;
  logic [SW-1:0]                       wk_wr_addr;
  logic signed [srss_pkg::SCORE_W-1:0] wk_wr_score;
  logic [SW-1:0]                       wk_wr_slot;
  logic                                wk_rd_en;
  logic [SW-1:0]                       wk_rd_addr;
  logic signed [srss_pkg::SCORE_W-1:0] wk_rd_score;
  logic [SW-1:0]                       wk_rd_slot;

  // persistent scores
  srss_store #(.ENTRANTS(ENTRANTS)) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (st_wr_en),
    .wr_addr  (st_wr_addr),
    .wr_score (st_wr_score),
    .rd_en    (st_rd_en),
    .rd_addr  (st_rd_addr),
    .rd_score (st_rd_score)
  );

  // sort working copy
  srss_work #(.ENTRANTS(ENTRANTS)) u_work (
    .clk      (clk),
    .wr_en    (wk_wr_en),
    .wr_addr  (wk_wr_addr),
    .wr_score (wk_wr_score),
    .wr_slot  (wk_wr_slot),
    .rd_en    (wk_rd_en),
    .rd_addr  (wk_rd_addr),
    .rd_score (wk_rd_score),
    .rd_slot  (wk_rd_slot)
  );

  // sequencer and compare unit
  srss_seq #(.ENTRANTS(ENTRANTS)) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_if),
    .out_if      (out_if),
    .st_wr_en    (st_wr_en),
    .st_wr_addr  (st_wr_addr),
    .st_wr_score (st_wr_score),
    .st_rd_en    (st_rd_en),
    .st_rd_addr  (st_rd_addr),
    .st_rd_score (st_rd_score),
    .wk_wr_en    (wk_wr_en),
    .wk_wr_addr  (wk_wr_addr),
    .wk_wr_score (wk_wr_score),
    .wk_wr_slot  (wk_wr_slot),
    .wk_rd_en    (wk_rd_en),
    .wk_rd_addr  (wk_rd_addr),
    .wk_rd_score (wk_rd_score),
    .wk_rd_slot  (wk_rd_slot)
  );

endmodule

>>> tb/sv/tb_score_ranking_selection_sort.sv
// testbench for the score ranking block: drives score updates and checks every ranked result
`timescale 1ns / 100ps

module tb_score_ranking_selection_sort;
  import srss_pkg::*;

  localparam int unsigned N          = ENTRANTS_DEF;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned DRAIN_WAIT = 60;
  localparam int unsigned UPDATES    = 140;

  typedef struct packed {
    logic [SLOT_W-1:0]         slot;
    logic signed [SCORE_W-1:0] score;
    logic                      last;
  } rank_t;

  // ranking predictor and store of expected ranks
  class rank_scoreboard;
    logic signed [SCORE_W-1:0] slot_score[N];
    rank_t                     ranks_due[$];
    int                        errors;

    function new();
      foreach (slot_score[i]) slot_score[i] = RESET_SCORE;
      errors = 0;
    endfunction

    function int pending();
      return ranks_due.size();
    endfunction

    task report(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    // apply one accepted update and queue the full descending ranking it causes
    function void note_update(input logic [SLOT_W-1:0] s, input logic signed [SCORE_W-1:0] v);
      logic signed [SCORE_W-1:0] wsc[N];
      logic [SLOT_W-1:0]         wsl[N];
      logic signed [SCORE_W-1:0] tsc;
      logic [SLOT_W-1:0]         tsl;
      int                        top;
      rank_t                     r;
      // writes to slots past the last entrant are dropped
      if (s < N) slot_score[s] = v;
      for (int p = 0; p < N; p++) begin
        wsc[p] = slot_score[p];
        wsl[p] = SLOT_W'(p);
      end
      // first maximum of the remaining positions is swapped into place
      for (int p = 0; p < N; p++) begin
        top = p;
        for (int q = p + 1; q < N; q++) begin
          if (wsc[top] < wsc[q]) top = q;
        end
        if (top != p) begin
          tsc = wsc[p];
          tsl = wsl[p];
          wsc[p] = wsc[top];
          wsl[p] = wsl[top];
          wsc[top] = tsc;
          wsl[top] = tsl;
        end
      end
      for (int p = 0; p < N; p++) begin
        r.slot  = wsl[p];
        r.score = wsc[p];
        r.last  = (p == N - 1);
        ranks_due.push_back(r);
      end
    endfunction

    // compare one ranked result against the oldest expected rank
    task check_result(input rank_t got);
      rank_t want;
      if (ranks_due.size() == 0) begin
        report($sformatf("unexpected result slot %0d score %0d last %0b",
                         got.slot, $signed(got.score), got.last));
        return;
      end
      want = ranks_due.pop_front();
      if (got.slot !== want.slot)
        report($sformatf("ranked_slot got %0d want %0d", got.slot, want.slot));
      if (got.score !== want.score)
        report($sformatf("ranked_score got %0d want %0d",
                         $signed(got.score), $signed(want.score)));
      if (got.last !== want.last)
        report($sformatf("last got %0b want %0b", got.last, want.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  srss_in_if  in_if();
  srss_out_if out_if();

  score_ranking_selection_sort #(.ENTRANTS(N)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  rank_scoreboard sb = new();
  int unsigned    idle_cycles = 0;

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // gap length: mostly none or short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(15, 50);
  endfunction

  // sample both channels at the rising edge
  always @(posedge clk) begin
    rank_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.slot  = out_if.ranked_slot;
      got.score = out_if.ranked_score;
      got.last  = out_if.last;
      sb.check_result(got);
    end
    if (rst_n && in_if.valid && in_if.ready)
      sb.note_update(in_if.slot, in_if.new_score);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("timeout after %0d idle cycles", IDLE_LIMIT);
        $display("tb_score_ranking_selection_sort NOT OK");
        $finish;
      end
    end
  end

  // result side back-pressure, with long stretches of steady ready
  initial begin
    int g;
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      out_if.ready = 1'b1;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(30, 80)) @(negedge clk);
      else repeat ($urandom_range(0, 6)) @(negedge clk);
      g = gap_len();
      if (g > 0) begin
        out_if.ready = 1'b0;
        repeat (g - 1) @(negedge clk);
      end
    end
  end

  // one update transfer, then a random sender gap; called just after a falling edge
  task automatic send_update(input logic [SLOT_W-1:0] s, input logic signed [SCORE_W-1:0] v);
    int g;
    in_if.valid     = 1'b1;
    in_if.slot      = s;
    in_if.new_score = v;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
    in_if.valid = 1'b0;
    g = gap_len();
    repeat (g) @(negedge clk);
  endtask

  // hold the sender until every queued rank has come out
  task automatic wait_drained();
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // pick a score that often collides with others to exercise tie order
  function automatic logic signed [SCORE_W-1:0] pick_score();
    case ($urandom_range(0, 5))
      0: return -16'sd1;
      1: return 16'sd0;
      2: return RESET_SCORE;
      3: return 16'sh7fff;
      4: return 16'sh8000;
      default: return SCORE_W'($urandom_range(98, 102));
    endcase
  endfunction

  initial begin
    int                        updates;
    logic [SLOT_W-1:0]         s;
    logic signed [SCORE_W-1:0] v;

    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.slot      = '0;
    in_if.new_score = '0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: dropped writes on reset state, extremes, bit patterns, ties
    send_update(3'd7, 16'sd5);
    send_update(3'd6, -16'sd1);
    send_update(3'd0, 16'sh7fff);
    send_update(3'd5, 16'sh8000);
    send_update(3'd3, 16'sd0);
    send_update(3'd1, -16'sd1);
    send_update(3'd4, 16'sd100);
    send_update(3'd0, 16'sd7);
    send_update(3'd1, 16'sd7);
    send_update(3'd2, 16'sd9);
    send_update(3'd3, 16'sd7);
    send_update(3'd4, 16'sd7);
    send_update(3'd5, 16'sd9);
    send_update(3'd1, 16'sh5555);
    send_update(3'd4, 16'shaaaa);
    send_update(3'd2, 16'sh8000);
    send_update(3'd5, 16'sh8000);
    send_update(3'd3, 16'sh7fff);
    send_update(3'd0, 16'sh7fff);
    wait_drained();
    send_update(3'd6, 16'sh1234);
    send_update(3'd5, 16'sd1);

    // random updates, a few to unused slots, with full drains now and then
    updates = 0;
    while (updates < UPDATES) begin
      if ($urandom_range(0, 11) == 0) s = SLOT_W'($urandom_range(N, 7));
      else s = SLOT_W'($urandom_range(0, N - 1));
      v = ($urandom_range(0, 1) == 0) ? pick_score() : SCORE_W'($urandom);
      send_update(s, v);
      updates++;
      if (updates % 45 == 44) wait_drained();
    end

    // drain, then let the block settle
    wait_drained();
    repeat (DRAIN_WAIT) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_score_ranking_selection_sort OK");
    end else begin
      $display("tb_score_ranking_selection_sort NOT OK");
    end
    $finish;
  end

endmodule
